/* sv/ccst_pkg.sv */
package ccst_pkg;

  // Table geometry
  localparam int unsigned Capacity = 64;
  localparam int unsigned IdxW     = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned PosW     = 6;
  localparam int unsigned WideW    = (CntW > PosW) ? CntW : PosW;
  localparam int unsigned SuitW    = 3;
  localparam int unsigned NumW     = 4;
  localparam int unsigned EntryW   = SuitW + NumW;

  typedef logic [EntryW-1:0] entry_t;
  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [CntW-1:0]   cnt_t;
  typedef logic [WideW-1:0]  wide_t;

  typedef enum logic [2:0] {
    ACT_INSERT   = 3'd0,
    ACT_REM_CARD = 3'd1,
    ACT_REM_NUM  = 3'd2,
    ACT_LOC_CARD = 3'd3,
    ACT_LOC_NUM  = 3'd4,
    ACT_PICKUP   = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    STAT_DONE      = 3'd0,
    STAT_PRESENT   = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_CLOSE,
    ST_RESULT
  } state_e;

  // Commands broadcast from the sequencer to the row of cells
  typedef struct packed {
    logic   rotate;
    logic   close;
    idx_t   close_pos;
    logic   load_key;
    entry_t key;
  } cell_ctrl_t;

endpackage

/* sv/ccst_cell.sv */
module ccst_cell (
  input  logic                   clk_i,
  input  ccst_pkg::idx_t         idx_i,
  input  ccst_pkg::cell_ctrl_t   ctrl_i,
  input  ccst_pkg::entry_t       nbr_i,
  output ccst_pkg::entry_t       entry_o
);

  ccst_pkg::entry_t entry_q;
  logic             load;

  // Take the neighbor on a rotate, or when closing a gap at or below this cell
  always_comb begin
    load = ctrl_i.rotate | (ctrl_i.close & (idx_i >= ctrl_i.close_pos));
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      entry_q <= nbr_i;
    end
  end

  assign entry_o = entry_q;

endmodule

/* sv/ccst_ctrl.sv */
module ccst_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [2:0]             action_i,
  input  logic [2:0]             card_suit_i,
  input  logic [3:0]             card_number_i,
  input  logic [5:0]             position_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             status_o,
  output logic [5:0]             found_position_o,
  output logic [2:0]             out_suit_o,
  output logic [3:0]             out_number_o,
  input  ccst_pkg::entry_t       head_i,
  output ccst_pkg::cell_ctrl_t   cell_ctrl_o
);

  ccst_pkg::state_e  state_q, state_d;
  ccst_pkg::action_e act_q;
  ccst_pkg::entry_t  key_q;
  logic [5:0]        r_q;
  ccst_pkg::idx_t    j_q;
  logic              found_q, found_d;
  ccst_pkg::idx_t    pos_q;
  ccst_pkg::entry_t  card_q;
  ccst_pkg::cnt_t    count_q, count_d;

  logic              out_valid_q;
  ccst_pkg::status_e out_status_q;
  logic [5:0]        out_pos_q;
  ccst_pkg::entry_t  out_card_q;

  ccst_pkg::wide_t   r_w, cnt_w, j_w, pos_w, diff_w;
  logic              last_step, is_full, in_range, hit, accept, out_load, is_remove;
  logic              m_card, m_num;
  ccst_pkg::status_e res_status;
  logic [5:0]        res_pos;
  ccst_pkg::entry_t  res_card;

  // Common widened views
  always_comb begin
    r_w       = ccst_pkg::WideW'(r_q);
    cnt_w     = ccst_pkg::WideW'(count_q);
    j_w       = ccst_pkg::WideW'(j_q);
    pos_w     = ccst_pkg::WideW'(pos_q);
    diff_w    = r_w - cnt_w;
    last_step = (j_q == ccst_pkg::idx_t'(ccst_pkg::Capacity - 1));
    is_full   = (count_q == ccst_pkg::cnt_t'(ccst_pkg::Capacity));
    in_range  = (ccst_pkg::cnt_t'(j_q) < count_q);
    accept    = (state_q == ccst_pkg::ST_IDLE) & in_valid_i;
    is_remove = act_q inside {ccst_pkg::ACT_REM_CARD, ccst_pkg::ACT_REM_NUM};
  end

  // Compare the head entry (pickup: scan index) to the request
  always_comb begin
    m_card = (head_i == key_q);
    m_num  = (head_i[ccst_pkg::NumW-1:0] == key_q[ccst_pkg::NumW-1:0]);
    hit    = 1'b0;
    if ((state_q == ccst_pkg::ST_SCAN) && in_range && !found_q) begin
      case (act_q)
        ccst_pkg::ACT_INSERT,
        ccst_pkg::ACT_REM_CARD,
        ccst_pkg::ACT_LOC_CARD: hit = m_card;
        ccst_pkg::ACT_REM_NUM,
        ccst_pkg::ACT_LOC_NUM:  hit = m_num;
        ccst_pkg::ACT_PICKUP:   hit = (j_w == r_w);
        default:                hit = 1'b0;
      endcase
    end
    found_d = found_q | hit;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ccst_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if ((action_i == ccst_pkg::ACT_PICKUP) && (count_q != '0)) begin
            state_d = ccst_pkg::ST_REDUCE;
          end else begin
            state_d = ccst_pkg::ST_SCAN;
          end
        end
      end
      ccst_pkg::ST_REDUCE: begin
        if (r_w < cnt_w) begin
          state_d = ccst_pkg::ST_SCAN;
        end
      end
      ccst_pkg::ST_SCAN: begin
        if (last_step) begin
          state_d = (is_remove && found_d) ? ccst_pkg::ST_CLOSE : ccst_pkg::ST_RESULT;
        end
      end
      ccst_pkg::ST_CLOSE: begin
        state_d = ccst_pkg::ST_RESULT;
      end
      ccst_pkg::ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ccst_pkg::ST_IDLE;
        end
      end
      default: state_d = ccst_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall_o            = (state_q != ccst_pkg::ST_IDLE);
    cell_ctrl_o.rotate    = (state_q == ccst_pkg::ST_SCAN);
    cell_ctrl_o.close     = (state_q == ccst_pkg::ST_CLOSE);
    cell_ctrl_o.close_pos = pos_q;
    cell_ctrl_o.load_key  = (state_q == ccst_pkg::ST_SCAN) && (act_q == ccst_pkg::ACT_INSERT)
                            && (ccst_pkg::cnt_t'(j_q) == count_q) && !found_q;
    cell_ctrl_o.key       = key_q;
    out_load              = (state_q == ccst_pkg::ST_RESULT) && (!out_valid_q || !out_stall_i);
  end

  // Build the result and the new fill count
  always_comb begin
    res_status = ccst_pkg::STAT_NOT_FOUND;
    res_pos    = '0;
    res_card   = '0;
    count_d    = count_q;
    case (act_q)
      ccst_pkg::ACT_INSERT: begin
        if (found_q) begin
          res_status = ccst_pkg::STAT_PRESENT;
          res_pos    = pos_w[5:0];
          res_card   = card_q;
        end else if (is_full) begin
          res_status = ccst_pkg::STAT_FULL;
        end else begin
          res_status = ccst_pkg::STAT_DONE;
          res_pos    = cnt_w[5:0];
          res_card   = key_q;
          count_d    = count_q + 1'b1;
        end
      end
      ccst_pkg::ACT_REM_CARD,
      ccst_pkg::ACT_REM_NUM: begin
        if (found_q) begin
          res_status = ccst_pkg::STAT_DONE;
          res_pos    = pos_w[5:0];
          res_card   = card_q;
          count_d    = count_q - 1'b1;
        end
      end
      ccst_pkg::ACT_LOC_CARD,
      ccst_pkg::ACT_LOC_NUM: begin
        if (found_q) begin
          res_status = ccst_pkg::STAT_DONE;
          res_pos    = pos_w[5:0];
          res_card   = card_q;
        end
      end
      ccst_pkg::ACT_PICKUP: begin
        if (count_q == '0) begin
          res_status = ccst_pkg::STAT_EMPTY;
        end else begin
          res_status = ccst_pkg::STAT_DONE;
          res_pos    = pos_w[5:0];
          res_card   = card_q;
        end
      end
      default: res_status = ccst_pkg::STAT_NOT_FOUND;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ccst_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      j_q         <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        found_q <= 1'b0;
        j_q     <= '0;
      end else if (state_q == ccst_pkg::ST_SCAN) begin
        found_q <= found_d;
        j_q     <= j_q + 1'b1;
      end
      if (out_load) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= ccst_pkg::action_e'(action_i);
      key_q <= {card_suit_i, card_number_i};
      r_q   <= position_i;
    end else if ((state_q == ccst_pkg::ST_REDUCE) && (r_w >= cnt_w)) begin
      r_q <= diff_w[5:0];
    end
    if (hit) begin
      pos_q  <= j_q;
      card_q <= head_i;
    end
    if (out_load) begin
      out_status_q <= res_status;
      out_pos_q    <= res_pos;
      out_card_q   <= res_card;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign found_position_o = out_pos_q;
  assign out_suit_o       = out_card_q[ccst_pkg::EntryW-1:ccst_pkg::NumW];
  assign out_number_o     = out_card_q[ccst_pkg::NumW-1:0];

endmodule

/* sv/compacting_card_set_table.sv */
// Operation: every request scans the whole row of cells before its result is registered;
//   a remove that finds its card adds a close step, and pickup on a non-empty list first
//   reduces its position modulo the count, one subtraction per cycle.
// Requests: one at a time; no new request is taken until the last result is registered;
//   the scan rotates the whole row of cells once and a stalled result holds off the next request.
// Reset: clears the fill count and the handshake state; cells are not cleared.
module compacting_card_set_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] action_i,
  input  logic [2:0] card_suit_i,
  input  logic [3:0] card_number_i,
  input  logic [5:0] position_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [5:0] found_position_o,
  output logic [2:0] out_suit_o,
  output logic [3:0] out_number_o
);

  ccst_pkg::cell_ctrl_t cell_ctrl;
  ccst_pkg::entry_t     cell_q [ccst_pkg::Capacity];
  ccst_pkg::entry_t     nbr    [ccst_pkg::Capacity];

  // Row of cells, each handing its entry to the one below
  for (genvar g = 0; g < ccst_pkg::Capacity; g++) begin : g_cell
    if (g == ccst_pkg::Capacity - 1) begin : g_tail
      // Recirculate the head, or drop the new card into the first free slot
      assign nbr[g] = cell_ctrl.load_key ? cell_ctrl.key : cell_q[0];
    end else begin : g_body
      assign nbr[g] = cell_q[g+1];
    end

    ccst_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (ccst_pkg::idx_t'(g)),
      .ctrl_i  (cell_ctrl),
      .nbr_i   (nbr[g]),
      .entry_o (cell_q[g])
    );
  end

  ccst_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .card_suit_i      (card_suit_i),
    .card_number_i    (card_number_i),
    .position_i       (position_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .out_suit_o       (out_suit_o),
    .out_number_o     (out_number_o),
    .head_i           (cell_q[0]),
    .cell_ctrl_o      (cell_ctrl)
  );

endmodule

/* sv/ccst_checker.sv */
module ccst_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [2:0] action_i,
  input logic [2:0] card_suit_i,
  input logic [3:0] card_number_i,
  input logic [5:0] position_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] status_o,
  input logic [5:0] found_position_o,
  input logic [2:0] out_suit_o,
  input logic [3:0] out_number_o
);

  // Block goes busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted but block not busy next cycle");

  // A new result only appears out of a busy block
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in flight");

  // Failure statuses carry no position or card
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ccst_pkg::STAT_NOT_FOUND || status_o == ccst_pkg::STAT_FULL
      || status_o == ccst_pkg::STAT_EMPTY))
    |-> (found_position_o == '0 && out_suit_o == '0 && out_number_o == '0))
    else $error("failure result carries a card");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o)
      && $stable(found_position_o)))
    else $error("stalled result dropped or changed");

endmodule

bind compacting_card_set_table ccst_checker u_ccst_checker (.*);

/* bench/ccst_checker.sv */
module tb_ccst_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  action_i,
  input  logic [2:0]  card_suit_i,
  input  logic [3:0]  card_number_i,
  input  logic [5:0]  position_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [5:0]  found_position_i,
  input  logic [2:0]  out_suit_i,
  input  logic [3:0]  out_number_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    ccst_pkg::status_e status;
    logic [5:0]        pos;
    logic [2:0]        suit;
    logic [3:0]        number;
  } outcome_t;

  // Shadow copy of the packed card list
  ccst_pkg::entry_t deck [ccst_pkg::Capacity];
  int unsigned      deck_size;

  outcome_t    awaited_outcomes [$];
  int unsigned mismatch_count;
  int unsigned results_seen;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("mismatch on result %0d, %s: got %0d, expected %0d",
             results_seen, what, got, want);
  endtask

  // Return the first matching position, or deck_size when none matches
  function automatic int unsigned find_card(input ccst_pkg::entry_t key, input bit by_number);
    for (int unsigned i = 0; i < deck_size; i++) begin
      if (by_number ? (deck[i][ccst_pkg::NumW-1:0] == key[ccst_pkg::NumW-1:0])
                    : (deck[i] == key))
        return i;
    end
    return deck_size;
  endfunction

  function automatic outcome_t card_at(input ccst_pkg::status_e st, input int unsigned at);
    outcome_t o;
    o.status = st;
    o.pos    = at[5:0];
    o.suit   = deck[at][ccst_pkg::EntryW-1:ccst_pkg::NumW];
    o.number = deck[at][ccst_pkg::NumW-1:0];
    return o;
  endfunction

  // Update the shadow list and queue what the block should answer
  task automatic apply_request(input logic [2:0] act, input logic [2:0] suit,
                               input logic [3:0] number, input logic [5:0] where);
    outcome_t         o;
    ccst_pkg::entry_t key;
    int unsigned      at;
    key = {suit, number};
    o = '0;
    o.status = ccst_pkg::STAT_NOT_FOUND;
    case (act)
      ccst_pkg::ACT_INSERT: begin
        at = find_card(key, 1'b0);
        if (at < deck_size) begin
          o = card_at(ccst_pkg::STAT_PRESENT, at);
        end else if (deck_size >= ccst_pkg::Capacity) begin
          o.status = ccst_pkg::STAT_FULL;
        end else begin
          deck[deck_size] = key;
          o = card_at(ccst_pkg::STAT_DONE, deck_size);
          deck_size++;
        end
      end
      ccst_pkg::ACT_REM_CARD, ccst_pkg::ACT_REM_NUM: begin
        at = find_card(key, act == ccst_pkg::ACT_REM_NUM);
        if (at < deck_size) begin
          o = card_at(ccst_pkg::STAT_DONE, at);
          // close the gap
          for (int unsigned i = at; i + 1 < deck_size; i++) deck[i] = deck[i + 1];
          deck_size--;
        end
      end
      ccst_pkg::ACT_LOC_CARD, ccst_pkg::ACT_LOC_NUM: begin
        at = find_card(key, act == ccst_pkg::ACT_LOC_NUM);
        if (at < deck_size) o = card_at(ccst_pkg::STAT_DONE, at);
      end
      ccst_pkg::ACT_PICKUP: begin
        if (deck_size == 0) o.status = ccst_pkg::STAT_EMPTY;
        else o = card_at(ccst_pkg::STAT_DONE, int'(where) % deck_size);
      end
      default: begin
      end
    endcase
    awaited_outcomes.push_back(o);
  endtask

  task automatic check_result();
    outcome_t want;
    if (awaited_outcomes.size() == 0) begin
      report_mismatch("result with no request outstanding, status", status_i, 0);
      return;
    end
    want = awaited_outcomes.pop_front();
    if (status_i !== want.status) report_mismatch("status", status_i, want.status);
    if (found_position_i !== want.pos)
      report_mismatch("found_position", found_position_i, want.pos);
    if (out_suit_i !== want.suit) report_mismatch("out_suit", out_suit_i, want.suit);
    if (out_number_i !== want.number)
      report_mismatch("out_number", out_number_i, want.number);
    results_seen++;
  endtask

  // Watch both channels; take the result first, it belongs to an older request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deck_size = 0;
      awaited_outcomes.delete();
      mismatch_count = 0;
      results_seen = 0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i)
        apply_request(action_i, card_suit_i, card_number_i, position_i);
      errors_o <= mismatch_count;
      pending_o <= awaited_outcomes.size();
    end
  end

endmodule

/* bench/tb_compacting_card_set_table.sv */
module tb_compacting_card_set_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  ActSpareLo   = 3'd6;
  localparam logic [2:0]  ActSpareHi   = 3'd7;
  localparam int unsigned LegalCards   = 70;
  localparam int unsigned FillItems    = 70;
  localparam int unsigned DrainItems   = 50;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 200;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] action_i = '0;
  logic [2:0] card_suit_i = '0;
  logic [3:0] card_number_i = '0;
  logic [5:0] position_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic [5:0] found_position_o;
  logic [2:0] out_suit_o;
  logic [3:0] out_number_o;

  int unsigned errors;
  int unsigned pending;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_go = 1'b0;

  compacting_card_set_table dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .card_suit_i     (card_suit_i),
    .card_number_i   (card_number_i),
    .position_i      (position_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .found_position_o(found_position_o),
    .out_suit_o      (out_suit_o),
    .out_number_o    (out_number_o)
  );

  tb_ccst_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .action_i        (action_i),
    .card_suit_i     (card_suit_i),
    .card_number_i   (card_number_i),
    .position_i      (position_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_i        (status_o),
    .found_position_i(found_position_o),
    .out_suit_i      (out_suit_o),
    .out_number_i    (out_number_o),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Bound the run
  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off when asked
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !held) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offer one request, idling first at random; return at the accepting edge
  task automatic send_request(input logic [2:0] act, input logic [6:0] card,
                              input logic [5:0] where);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    card_suit_i   <= card[6:4];
    card_number_i <= card[3:0];
    position_i    <= where;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Hold the sender until every queued result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [6:0] pick_card();
    if ($urandom_range(99) < 85)
      return {3'($urandom_range(4)), 4'($urandom_range(13))};
    return 7'($urandom);
  endfunction

  task automatic send_mixed(input int unsigned count);
    int unsigned r;
    logic [2:0]  act;
    for (int unsigned k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 30)      act = ccst_pkg::ACT_INSERT;
      else if (r < 45) act = ccst_pkg::ACT_REM_CARD;
      else if (r < 60) act = ccst_pkg::ACT_REM_NUM;
      else if (r < 72) act = ccst_pkg::ACT_LOC_CARD;
      else if (r < 84) act = ccst_pkg::ACT_LOC_NUM;
      else if (r < 97) act = ccst_pkg::ACT_PICKUP;
      else             act = $urandom_range(1) ? ActSpareHi : ActSpareLo;
      send_request(act, pick_card(), 6'($urandom_range(63)));
    end
  endtask

  // Fill to capacity, mix, drain by number, mix again
  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input bit with_hold);
    logic [6:0]  legal [LegalCards];
    logic [6:0]  swap;
    int unsigned j;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (with_hold) hold_go <= 1'b1;
    for (int unsigned k = 0; k < LegalCards; k++)
      legal[k] = {3'(k / 14), 4'(k % 14)};
    for (int unsigned k = LegalCards - 1; k > 0; k--) begin
      j = $urandom_range(k);
      swap = legal[k];
      legal[k] = legal[j];
      legal[j] = swap;
    end
    for (int unsigned k = 0; k < FillItems; k++)
      send_request(ccst_pkg::ACT_INSERT, legal[k], 6'($urandom_range(63)));
    send_mixed(40);
    for (int unsigned k = 0; k < DrainItems; k++)
      send_request(ccst_pkg::ACT_REM_NUM, 7'($urandom), 6'($urandom_range(63)));
    send_mixed(20);
    drain_results();
  endtask

  // Stimulus and verdict
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 36;
    recv_idle_pct = 88;

    // empty list
    send_request(ccst_pkg::ACT_PICKUP,   7'h00, 6'd0);
    send_request(ccst_pkg::ACT_REM_CARD, 7'h00, 6'd0);
    send_request(ccst_pkg::ACT_REM_NUM,  7'h05, 6'd0);
    send_request(ccst_pkg::ACT_LOC_CARD, 7'h13, 6'd0);
    send_request(ccst_pkg::ACT_LOC_NUM,  7'h09, 6'd0);
    // extremes, out-of-range card, duplicate insert
    send_request(ccst_pkg::ACT_INSERT,   {3'd0, 4'd0},  6'd0);
    send_request(ccst_pkg::ACT_INSERT,   {3'd7, 4'd15}, 6'd63);
    send_request(ccst_pkg::ACT_INSERT,   {3'd4, 4'd13}, 6'd0);
    send_request(ccst_pkg::ACT_INSERT,   {3'd4, 4'd13}, 6'd0);
    send_request(ccst_pkg::ACT_INSERT,   {3'd1, 4'd13}, 6'd0);
    send_request(ccst_pkg::ACT_LOC_CARD, {3'd7, 4'd15}, 6'd0);
    send_request(ccst_pkg::ACT_LOC_NUM,  {3'd2, 4'd13}, 6'd0);
    send_request(ccst_pkg::ACT_LOC_NUM,  {3'd0, 4'd9},  6'd0);
    send_request(ccst_pkg::ACT_PICKUP,   7'h00, 6'd63);
    send_request(ccst_pkg::ACT_PICKUP,   7'h7f, 6'd0);
    // unused codes
    send_request(ActSpareLo,             {3'd1, 4'd1},  6'd5);
    send_request(ActSpareHi,             {3'd4, 4'd13}, 6'd63);
    // removes with shift, then back to empty
    send_request(ccst_pkg::ACT_REM_NUM,  {3'd0, 4'd13}, 6'd0);
    send_request(ccst_pkg::ACT_REM_CARD, {3'd0, 4'd0},  6'd0);
    send_request(ccst_pkg::ACT_REM_CARD, {3'd2, 4'd2},  6'd0);
    send_request(ccst_pkg::ACT_PICKUP,   7'h00, 6'd63);
    send_request(ccst_pkg::ACT_REM_NUM,  {3'd3, 4'd15}, 6'd0);
    send_request(ccst_pkg::ACT_REM_CARD, {3'd1, 4'd13}, 6'd0);
    send_request(ccst_pkg::ACT_PICKUP,   7'h00, 6'd63);
    drain_results();

    run_phase(36, 88, 1'b0);
    run_phase(88, 36, 1'b0);
    run_phase(0, 0, 1'b1);

    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
